FILE: hw/rtl/rd256_pkg.sv
// Shared types and constants for the 256-bit restoring divider.
// No dependencies; imported by every module of the block.
`default_nettype none
package rd256_pkg;

	localparam int WORD_BITS    = 64;
	localparam int WORDS        = 4;
	localparam int MAX_BITS     = WORD_BITS * WORDS;
	// operand width actually divided, 64..256; bits above it are ignored
	localparam int OPERAND_BITS = 256;
	localparam int CNT_W        = $clog2(OPERAND_BITS);

	typedef logic [WORD_BITS-1:0]    word_t;
	typedef logic [OPERAND_BITS-1:0] opnd_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef struct packed {
		word_t dividend_word3;
		word_t dividend_word2;
		word_t dividend_word1;
		word_t dividend_word0;
		word_t divisor_word3;
		word_t divisor_word2;
		word_t divisor_word1;
		word_t divisor_word0;
	} operands_t;

	typedef struct packed {
		word_t quotient_word3;
		word_t quotient_word2;
		word_t quotient_word1;
		word_t quotient_word0;
		word_t remainder_word3;
		word_t remainder_word2;
		word_t remainder_word1;
		word_t remainder_word0;
		logic  divide_by_zero;
	} result_t;

	// sequencer -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} rd256_ctrl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic div_zero;
	} rd256_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rd256_datapath.sv
// Shift-and-subtract datapath: partial remainder, dividend/quotient shifter,
// one shared trial subtractor and the result register. Uses rd256_pkg.
`default_nettype none
module rd256_datapath
	import rd256_pkg::*;
(
	input  wire logic          clk,
	input  wire operands_t     operands,
	input  wire rd256_ctrl_t   ctrl,
	output rd256_status_t      status,
	output result_t            result
);

	opnd_t   num_q;   // dividend bits in, quotient bits shift in at the bottom
	opnd_t   den_q;
	opnd_t   rem_q;
	logic    zero_q;
	result_t result_q;

	logic [MAX_BITS-1:0]     dvd_full;
	logic [MAX_BITS-1:0]     dvs_full;
	opnd_t                   dvd_in;
	opnd_t                   dvs_in;
	logic [OPERAND_BITS+1:0] trial;
	logic                    qbit;
	opnd_t                   quo;
	opnd_t                   rmd;
	logic [MAX_BITS-1:0]     quo_full;
	logic [MAX_BITS-1:0]     rmd_full;

	assign dvd_full = {operands.dividend_word3, operands.dividend_word2,
		operands.dividend_word1, operands.dividend_word0};
	assign dvs_full = {operands.divisor_word3, operands.divisor_word2,
		operands.divisor_word1, operands.divisor_word0};
	assign dvd_in = dvd_full[OPERAND_BITS-1:0];
	assign dvs_in = dvs_full[OPERAND_BITS-1:0];

	assign status.div_zero = (dvs_in == '0);

	// shifted remainder keeps its carry bit; one guard bit for the borrow
	assign trial = {1'b0, rem_q, num_q[OPERAND_BITS-1]} - {2'b00, den_q};
	assign qbit  = ~trial[OPERAND_BITS+1];

	assign quo = zero_q ? '0 : num_q;
	assign rmd = zero_q ? num_q : rem_q;

	always_comb begin
		quo_full = '0;
		rmd_full = '0;
		quo_full[OPERAND_BITS-1:0] = quo;
		rmd_full[OPERAND_BITS-1:0] = rmd;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q  <= dvd_in;
			den_q  <= dvs_in;
			rem_q  <= '0;
			zero_q <= status.div_zero;
		end else if (ctrl.step) begin
			num_q <= {num_q[OPERAND_BITS-2:0], qbit};
			if (qbit) begin
				rem_q <= trial[OPERAND_BITS-1:0];
			end else begin
				rem_q <= {rem_q[OPERAND_BITS-2:0], num_q[OPERAND_BITS-1]};
			end
		end
		if (ctrl.finish) begin
			result_q.quotient_word3  <= quo_full[4*WORD_BITS-1:3*WORD_BITS];
			result_q.quotient_word2  <= quo_full[3*WORD_BITS-1:2*WORD_BITS];
			result_q.quotient_word1  <= quo_full[2*WORD_BITS-1:WORD_BITS];
			result_q.quotient_word0  <= quo_full[WORD_BITS-1:0];
			result_q.remainder_word3 <= rmd_full[4*WORD_BITS-1:3*WORD_BITS];
			result_q.remainder_word2 <= rmd_full[3*WORD_BITS-1:2*WORD_BITS];
			result_q.remainder_word1 <= rmd_full[2*WORD_BITS-1:WORD_BITS];
			result_q.remainder_word0 <= rmd_full[WORD_BITS-1:0];
			result_q.divide_by_zero  <= zero_q;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

FILE: hw/rtl/rd256_ctrl.sv
// Sequencer for the divider: accepts a request, counts OPERAND_BITS steps,
// then loads the result register and strobes done. Uses rd256_pkg.
`default_nettype none
module rd256_ctrl
	import rd256_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rd256_status_t status,
	output rd256_ctrl_t        ctrl,
	output logic               busy,
	output logic               done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t state_q;
	cnt_t   cnt_q;
	logic   done_q;

	assign busy        = (state_q != ST_IDLE);
	assign ctrl.load   = start && (state_q == ST_IDLE);
	assign ctrl.step   = (state_q == ST_RUN);
	assign ctrl.finish = (state_q == ST_FINISH);
	assign done        = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q <= cnt_t'(OPERAND_BITS - 1);
						// zero divisor needs no steps
						state_q <= status.div_zero ? ST_FINISH : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/restoring_divider_256.sv
// Top level of the 256-bit restoring divider: sequencer plus datapath.
// Depends on rd256_pkg, rd256_ctrl and rd256_datapath.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-------------------------------
//   request  | operands (operands_t)    | taken when start && !busy
//   result   | result (result_t)        | valid for one cycle with done
//
// One quotient bit per cycle through a single trial subtractor: a request
// runs through the OPERAND_BITS steps of ST_RUN and then ST_FINISH before done;
// a zero divisor skips ST_RUN. busy is low again in the cycle done is shown, so the
// next request may be taken then. Reset clears the sequencer only. The result
// is held in its own register and cannot be stalled by the receiver.
`default_nettype none
module restoring_divider_256
	import rd256_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire operands_t operands,
	output logic           done,
	output result_t        result
);

	rd256_ctrl_t   ctrl;
	rd256_status_t status;

	rd256_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	rd256_datapath u_dp (
		.clk      (clk),
		.operands (operands),
		.ctrl     (ctrl),
		.status   (status),
		.result   (result)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/rd256_checker.sv
// Port-level checks for restoring_divider_256, bound to the top level.
// Uses rd256_pkg types.
`default_nettype none
module rd256_checker
	import rd256_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      done,
	input wire result_t   result
);

	// an accepted request keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but busy not raised");

	// done only comes at the end of a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("done without preceding busy");

	// strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// zero divisor gives zero quotient
	a_dbz_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.divide_by_zero) |->
		(result.quotient_word0 == '0 && result.quotient_word1 == '0 &&
		 result.quotient_word2 == '0 && result.quotient_word3 == '0))
		else $error("non-zero quotient on divide by zero");

endmodule

bind restoring_divider_256 rd256_checker u_rd256_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.result   (result)
);
`default_nettype wire
